### rtl/acr_pkg.sv
`default_nettype none

package acr_pkg;

    // Internal coordinate width of the datapath
    localparam int COORD_BITS    = 32;
    // Fixed widths of the channel fields
    localparam int IO_BITS       = 32;
    localparam int DIM_BITS      = 31;
    // Inputs are sign-extended from this many bits
    localparam int IN_BITS       = (COORD_BITS < IO_BITS) ? COORD_BITS : IO_BITS;
    // Edge sums and depths need three bits of headroom over a coordinate or a box size
    localparam int CALC_BITS     =
        ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS + 1) + 3;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = DIM_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HEIGHT = 1'd1;

    // Saturation limits of the signed COORD_BITS range, at CALC_BITS
    localparam logic signed [CALC_BITS-1:0] SAT_HI =
        {{(CALC_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [CALC_BITS-1:0] SAT_LO =
        {{(CALC_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    typedef logic signed [CALC_BITS-1:0] t_calc;

    // Sticky side flags, top in bit 0
    typedef struct packed {
        logic right;
        logic left;
        logic bottom;
        logic top;
    } t_side_flags;

    typedef struct packed {
        logic signed [IO_BITS-1:0] pos_x;
        logic signed [IO_BITS-1:0] pos_y;
        logic signed [IO_BITS-1:0] obs_left;
        logic signed [IO_BITS-1:0] obs_right;
        logic signed [IO_BITS-1:0] obs_top;
        logic signed [IO_BITS-1:0] obs_bottom;
        logic                      obs_is_boundary;
        logic                      mover_dead;
    } t_in_item;

    typedef struct packed {
        logic                      colliding;
        logic signed [IO_BITS-1:0] new_x;
        logic signed [IO_BITS-1:0] new_y;
        t_side_flags               flags;
        logic                      ground_contact;
    } t_out_item;

    // Sign-extend an input coordinate into the datapath width
    function automatic t_calc coord_in(input logic [IO_BITS-1:0] v);
        logic signed [IN_BITS-1:0] s;
        s = signed'(v[IN_BITS-1:0]);
        return CALC_BITS'(s);
    endfunction

    // Clamp to the signed COORD_BITS range, keep the low output bits
    function automatic logic [IO_BITS-1:0] sat_coord(input t_calc v);
        t_calc c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[IO_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/acr_in_if.sv
`default_nettype none

interface acr_in_if import acr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [IO_BITS-1:0] pos_x;
    logic signed [IO_BITS-1:0] pos_y;
    logic signed [IO_BITS-1:0] obs_left;
    logic signed [IO_BITS-1:0] obs_right;
    logic signed [IO_BITS-1:0] obs_top;
    logic signed [IO_BITS-1:0] obs_bottom;
    logic                      obs_is_boundary;
    logic                      mover_dead;

    modport source (
        output valid, pos_x, pos_y, obs_left, obs_right, obs_top, obs_bottom,
               obs_is_boundary, mover_dead,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, obs_left, obs_right, obs_top, obs_bottom,
               obs_is_boundary, mover_dead,
        output ready
    );
endinterface

`default_nettype wire

### rtl/acr_out_if.sv
`default_nettype none

interface acr_out_if import acr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      colliding;
    logic signed [IO_BITS-1:0] new_x;
    logic signed [IO_BITS-1:0] new_y;
    logic                      hit_top;
    logic                      hit_bottom;
    logic                      hit_left;
    logic                      hit_right;
    logic                      ground_contact;

    modport source (
        output valid, colliding, new_x, new_y, hit_top, hit_bottom, hit_left,
               hit_right, ground_contact,
        input  ready
    );

    modport sink (
        input  valid, colliding, new_x, new_y, hit_top, hit_bottom, hit_left,
               hit_right, ground_contact,
        output ready
    );
endinterface

`default_nettype wire

### rtl/acr_resolve.sv
`default_nettype none

// Overlap test, penetration depths and minimum-depth snap for one item
module acr_resolve import acr_pkg::*; (
    input  t_in_item                  i_item,
    input  logic [DIM_BITS-1:0]       i_box_width,
    input  logic [DIM_BITS-1:0]       i_box_height,
    input  t_side_flags               i_flags,
    output t_out_item                 o_result
);

    t_calc px, py, ol, orr, ot, ob, w, h;
    t_calc m_right, m_bottom;
    t_calc pt, pb, pl, pr;
    logic  overlap;

    // Extend everything into the datapath width
    assign px  = coord_in(i_item.pos_x);
    assign py  = coord_in(i_item.pos_y);
    assign ol  = coord_in(i_item.obs_left);
    assign orr = coord_in(i_item.obs_right);
    assign ot  = coord_in(i_item.obs_top);
    assign ob  = coord_in(i_item.obs_bottom);
    assign w   = CALC_BITS'(i_box_width);
    assign h   = CALC_BITS'(i_box_height);

    // Mover edges; y grows upward so the bottom is below the top
    assign m_right  = px + w;
    assign m_bottom = py - h;

    // Inclusive overlap, gated by boundary and alive
    assign overlap = i_item.obs_is_boundary && !i_item.mover_dead &&
                     (m_right >= ol) && (px <= orr) &&
                     (py >= ob) && (m_bottom <= ot);

    // Penetration depths
    assign pt = ot  - m_bottom;
    assign pb = py  - ob;
    assign pl = m_right - ol;
    assign pr = orr - px;

    // Snap onto the edge of the strictly smallest depth; a tie changes nothing
    always_comb begin
        o_result.colliding      = overlap;
        o_result.new_x          = px[IO_BITS-1:0];
        o_result.new_y          = py[IO_BITS-1:0];
        o_result.flags          = i_flags;
        o_result.ground_contact = 1'b0;
        if (overlap) begin
            priority if (pt < pb && pt < pl && pt < pr) begin
                o_result.new_y          = sat_coord(ot + h);
                o_result.flags          = '{right: 1'b0, left: 1'b0, bottom: 1'b0,
                                            top: 1'b1};
                o_result.ground_contact = 1'b1;
            end else if (pb < pt && pb < pl && pb < pr) begin
                o_result.new_y = ob[IO_BITS-1:0];
                o_result.flags = '{right: 1'b0, left: 1'b0, bottom: 1'b1, top: 1'b0};
            end else if (pl < pt && pl < pb && pl < pr) begin
                o_result.new_x = sat_coord(ol - w);
                o_result.flags = '{right: 1'b0, left: 1'b1, bottom: 1'b0, top: 1'b0};
            end else if (pr < pt && pr < pb && pr < pl) begin
                o_result.new_x = orr[IO_BITS-1:0];
                o_result.flags = '{right: 1'b1, left: 1'b0, bottom: 1'b0, top: 1'b0};
            end else begin
                o_result.flags = i_flags;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/aabb_collision_resolver_top.sv
`default_nettype none

// Channel   Dir  Handshake            Payload
// i_in      in   valid/ready          mover position, obstacle edges, enables
// o_out     out  valid/ready          colliding, new position, side flags, ground
// i_cfg_*   in   write enable only    register index, 31-bit data
//
// Two register stages: input register, then resolve logic into the result
// register. One transfer per cycle sustained while the output is ready.
// Side flags are updated as an item moves into the result register.
// While a result waits, the input side stays ready only as long as the
// input register is empty. Reset clears flags, box size and valids.
module aabb_collision_resolver_top import acr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    acr_in_if.sink                   i_in,
    acr_out_if.source                o_out
);

    logic                r_s1_valid;
    t_in_item            r_s1;
    logic                r_out_valid;
    t_out_item           r_out;
    t_side_flags         r_flags;
    logic [DIM_BITS-1:0] r_box_width;
    logic [DIM_BITS-1:0] r_box_height;

    logic                out_free;
    logic                s1_adv;
    logic                in_xfer;
    t_in_item            in_item;
    t_out_item           n_out;

    // Stage control
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_xfer    = i_in.valid && i_in.ready;

    assign in_item = '{
        pos_x:           i_in.pos_x,
        pos_y:           i_in.pos_y,
        obs_left:        i_in.obs_left,
        obs_right:       i_in.obs_right,
        obs_top:         i_in.obs_top,
        obs_bottom:      i_in.obs_bottom,
        obs_is_boundary: i_in.obs_is_boundary,
        mover_dead:      i_in.mover_dead
    };

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width  <= '0;
            r_box_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BOX_WIDTH:  r_box_width  <= i_cfg_data;
                REG_BOX_HEIGHT: r_box_height <= i_cfg_data;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= in_item;
        end
    end

    acr_resolve u_resolve (
        .i_item       (r_s1),
        .i_box_width  (r_box_width),
        .i_box_height (r_box_height),
        .i_flags      (r_flags),
        .o_result     (n_out)
    );

    // Result register and sticky flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_flags <= n_out.flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.colliding      = r_out.colliding;
    assign o_out.new_x          = r_out.new_x;
    assign o_out.new_y          = r_out.new_y;
    assign o_out.hit_top        = r_out.flags.top;
    assign o_out.hit_bottom     = r_out.flags.bottom;
    assign o_out.hit_left       = r_out.flags.left;
    assign o_out.hit_right      = r_out.flags.right;
    assign o_out.ground_contact = r_out.ground_contact;

    // Landing implies a collision resolved on top
    a_ground_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ground_contact |-> o_out.hit_top && o_out.colliding)
        else $error("ground contact without top hit");

    // At most one side flag is ever set
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_flags))
        else $error("more than one side flag set");

    // Flags change only when an item moves into the result register
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_flags))
        else $error("side flags changed without a transfer");

    // A waiting result does not block an empty input register
    a_accept_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready && !r_s1_valid |-> i_in.ready)
        else $error("input blocked while input register empty");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import acr_pkg::*;

    // Datapath width of the predictor: coordinates or box size plus headroom for sums
    localparam int WIDE_BITS =
        ((COORD_BITS > CFG_DATA_BITS) ? COORD_BITS : CFG_DATA_BITS + 1) + 3;
    localparam int SEXT_BITS = (COORD_BITS < IO_BITS) ? COORD_BITS : IO_BITS;
    typedef logic signed [WIDE_BITS-1:0] wide_t;
    localparam wide_t POS_LIMIT = (wide_t'(1) <<< (COORD_BITS - 1)) - wide_t'(1);
    localparam wide_t NEG_LIMIT = -POS_LIMIT - wide_t'(1);

    localparam int UNIT     = 32'h0001_0000;   // 1.0 in Q16.16
    localparam int CMAX     = 32'h7FFF_FFFF;
    localparam int CMIN     = -2147483647 - 1;
    localparam logic [CFG_DATA_BITS-1:0] DIM_MAX = '1;
    localparam int CYCLE_LIMIT = 300000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    acr_in_if  in_ch ();
    acr_out_if out_ch ();

    aabb_collision_resolver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: box size and sticky side flags
    logic [CFG_DATA_BITS-1:0] box_w = '0;
    logic [CFG_DATA_BITS-1:0] box_h = '0;
    t_side_flags              side_state = '0;

    t_in_item  pend_q[$];
    t_out_item expect_q[$];
    int queued_cnt   = 0;
    int taken_cnt    = 0;
    int results_seen = 0;
    int mismatch_cnt = 0;
    int cycles       = 0;
    bit calm         = 1'b0;
    bit in_taken     = 1'b0;
    bit long_hold_done = 1'b0;
    int src_gap      = 0;
    int sink_wait    = 0;

    function automatic wide_t widen_coord(input logic [IO_BITS-1:0] v);
        return {{(WIDE_BITS-SEXT_BITS){v[SEXT_BITS-1]}}, v[SEXT_BITS-1:0]};
    endfunction

    function automatic logic [IO_BITS-1:0] clamp_coord(input wide_t v);
        wide_t c;
        c = (v > POS_LIMIT) ? POS_LIMIT : ((v < NEG_LIMIT) ? NEG_LIMIT : v);
        return c[IO_BITS-1:0];
    endfunction

    // Overlap test and minimum-penetration snap; updates the sticky flags
    function automatic t_out_item resolve_contact(input t_in_item it);
        wide_t px, py, ol, orr, ot, ob, w, h;
        wide_t d_top, d_bot, d_left, d_right;
        t_out_item r;
        px  = widen_coord(it.pos_x);
        py  = widen_coord(it.pos_y);
        ol  = widen_coord(it.obs_left);
        orr = widen_coord(it.obs_right);
        ot  = widen_coord(it.obs_top);
        ob  = widen_coord(it.obs_bottom);
        w   = {{(WIDE_BITS-CFG_DATA_BITS){1'b0}}, box_w};
        h   = {{(WIDE_BITS-CFG_DATA_BITS){1'b0}}, box_h};
        r = '0;
        r.new_x = px[IO_BITS-1:0];
        r.new_y = py[IO_BITS-1:0];
        if (it.obs_is_boundary && !it.mover_dead && px + w >= ol && px <= orr &&
            py >= ob && py - h <= ot) begin
            d_top   = ot - (py - h);
            d_bot   = py - ob;
            d_left  = px + w - ol;
            d_right = orr - px;
            r.colliding = 1'b1;
            // strict minimum only; a tie leaves position and flags alone
            if (d_top < d_bot && d_top < d_left && d_top < d_right) begin
                r.new_y = clamp_coord(ot + h);
                side_state = '0;
                side_state.top = 1'b1;
                r.ground_contact = 1'b1;
            end else if (d_bot < d_top && d_bot < d_left && d_bot < d_right) begin
                r.new_y = ob[IO_BITS-1:0];
                side_state = '0;
                side_state.bottom = 1'b1;
            end else if (d_left < d_top && d_left < d_bot && d_left < d_right) begin
                r.new_x = clamp_coord(ol - w);
                side_state = '0;
                side_state.left = 1'b1;
            end else if (d_right < d_top && d_right < d_bot && d_right < d_left) begin
                r.new_x = orr[IO_BITS-1:0];
                side_state = '0;
                side_state.right = 1'b1;
            end
        end
        r.flags = side_state;
        return r;
    endfunction

    function automatic t_in_item mk_item(input int px, input int py, input int ol,
                                         input int orr, input int ot, input int ob,
                                         input bit bnd, input bit dead);
        t_in_item it;
        it.pos_x = px;
        it.pos_y = py;
        it.obs_left = ol;
        it.obs_right = orr;
        it.obs_top = ot;
        it.obs_bottom = ob;
        it.obs_is_boundary = bnd;
        it.mover_dead = dead;
        return it;
    endfunction

    // Uniform pick from lo..hi on a grid of the given step, anchored at lo
    function automatic longint pick_on_grid(input longint lo, input longint hi,
                                            input longint step);
        longint unsigned span;
        longint unsigned r;
        if (hi <= lo) return lo;
        span = longint'((hi - lo) / step) + 1;
        r = {$urandom, $urandom};
        return lo + step * longint'(r % span);
    endfunction

    // Mostly movers placed around an obstacle, some pure noise
    function automatic t_in_item rand_item();
        t_in_item it;
        longint step, ol, orr, ob, ot, px, py, w, h, base;
        if ($urandom_range(0, 9) < 2) begin
            it = mk_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 1), $urandom_range(0, 1));
            return it;
        end
        case ($urandom_range(0, 2))
            0: begin
                step = 1;
            end
            1: begin
                step = 64'h4000;
            end
            default: begin
                step = UNIT;
            end
        endcase
        w = longint'(box_w);
        h = longint'(box_h);
        ol = pick_on_grid(-64 * step, 64 * step, step);
        ob = pick_on_grid(-64 * step, 64 * step, step);
        // occasional inverted obstacle
        if ($urandom_range(0, 15) == 0) begin
            orr = ol - pick_on_grid(step, 16 * step, step);
        end else begin
            orr = pick_on_grid(ol, ol + 64 * step, step);
        end
        if ($urandom_range(0, 15) == 0) begin
            ot = ob - pick_on_grid(step, 16 * step, step);
        end else begin
            ot = pick_on_grid(ob, ob + 64 * step, step);
        end
        px = pick_on_grid(ol - w - 4 * step, orr + 4 * step, step);
        py = pick_on_grid(ob - 4 * step, ot + h + 4 * step, step);
        base = 0;
        if ($urandom_range(0, 3) == 0) begin
            base = longint'(int'($urandom));
        end
        it = mk_item(32'(px + base), 32'(py + base), 32'(ol + base), 32'(orr + base),
                     32'(ot + base), 32'(ob + base),
                     $urandom_range(0, 15) != 0, $urandom_range(0, 15) == 0);
        return it;
    endfunction

    task automatic send(input t_in_item it);
        pend_q = {pend_q, it};
        queued_cnt++;
    endtask

    // Wait until every queued item has been taken and answered
    task automatic drain();
        while (taken_cnt != queued_cnt || expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_box(input logic [CFG_DATA_BITS-1:0] wv,
                           input logic [CFG_DATA_BITS-1:0] hv);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_BOX_WIDTH;
        i_cfg_data  <= wv;
        @(negedge i_clk);
        i_cfg_index <= REG_BOX_HEIGHT;
        i_cfg_data  <= hv;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        box_w = wv;
        box_h = hv;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Input driver: one item per transfer, random idle bursts
    always @(negedge i_clk) begin : drive_in
        t_in_item nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
            // hold the offered item until it is taken
        end else if (src_gap > 0) begin
            src_gap     <= src_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            src_gap     <= $urandom_range(0, 12);
            in_ch.valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
            nxt = pend_q.pop_front();
            in_ch.valid           <= 1'b1;
            in_ch.pos_x           <= nxt.pos_x;
            in_ch.pos_y           <= nxt.pos_y;
            in_ch.obs_left        <= nxt.obs_left;
            in_ch.obs_right       <= nxt.obs_right;
            in_ch.obs_top         <= nxt.obs_top;
            in_ch.obs_bottom      <= nxt.obs_bottom;
            in_ch.obs_is_boundary <= nxt.obs_is_boundary;
            in_ch.mover_dead      <= nxt.mover_dead;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait    <= sink_wait - 1;
            out_ch.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 400 && pend_q.size() > 20) begin
            long_hold_done <= 1'b1;
            sink_wait      <= 299;
            out_ch.ready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_wait    <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Check result transfers, then predict for the input transfer
    always @(posedge i_clk) begin : watch
        t_out_item got;
        t_out_item want;
        t_in_item  seen;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                got.colliding      = out_ch.colliding;
                got.new_x          = out_ch.new_x;
                got.new_y          = out_ch.new_y;
                got.flags.top      = out_ch.hit_top;
                got.flags.bottom   = out_ch.hit_bottom;
                got.flags.left     = out_ch.hit_left;
                got.flags.right    = out_ch.hit_right;
                got.ground_contact = out_ch.ground_contact;
                if (expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatch_cnt++;
                end else begin
                    want = expect_q.pop_front();
                    check_field("colliding", want.colliding, got.colliding);
                    check_field("new_x", want.new_x, got.new_x);
                    check_field("new_y", want.new_y, got.new_y);
                    check_field("hit_top", want.flags.top, got.flags.top);
                    check_field("hit_bottom", want.flags.bottom, got.flags.bottom);
                    check_field("hit_left", want.flags.left, got.flags.left);
                    check_field("hit_right", want.flags.right, got.flags.right);
                    check_field("ground_contact", want.ground_contact, got.ground_contact);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                seen.pos_x           = in_ch.pos_x;
                seen.pos_y           = in_ch.pos_y;
                seen.obs_left        = in_ch.obs_left;
                seen.obs_right       = in_ch.obs_right;
                seen.obs_top         = in_ch.obs_top;
                seen.obs_bottom      = in_ch.obs_bottom;
                seen.obs_is_boundary = in_ch.obs_is_boundary;
                seen.mover_dead      = in_ch.mover_dead;
                expect_q = {expect_q, resolve_contact(seen)};
                taken_cnt++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        logic [CFG_DATA_BITS-1:0] wv;
        logic [CFG_DATA_BITS-1:0] hv;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = '0;
        i_cfg_data            = '0;
        in_ch.valid           = 1'b0;
        in_ch.pos_x           = '0;
        in_ch.pos_y           = '0;
        in_ch.obs_left        = '0;
        in_ch.obs_right       = '0;
        in_ch.obs_top         = '0;
        in_ch.obs_bottom      = '0;
        in_ch.obs_is_boundary = 1'b0;
        in_ch.mover_dead      = 1'b0;
        out_ch.ready          = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset box size is zero: a point mover
        send(mk_item(10 * UNIT, 50 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));
        send(mk_item(0, 0, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));
        drain();

        // Directed: obstacle spans 0..100 on both axes, mover 16 x 32
        set_box(16 * UNIT, 32 * UNIT);
        send(mk_item(40 * UNIT, 130 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));  // top
        send(mk_item(40 * UNIT, 2 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));    // bottom
        send(mk_item(-14 * UNIT, 66 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));  // left
        send(mk_item(98 * UNIT, 66 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));   // right
        send(mk_item(-14 * UNIT, 130 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0)); // tie
        // edges just touching, then one step apart
        send(mk_item(-16 * UNIT, 66 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));
        send(mk_item(-16 * UNIT - 1, 66 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));
        // collision disabled
        send(mk_item(40 * UNIT, 130 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 0, 0));
        send(mk_item(40 * UNIT, 130 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 1, 1));
        send(mk_item(40 * UNIT, 130 * UNIT, 0, 100 * UNIT, 100 * UNIT, 0, 0, 1));
        // snapped position saturates at the top and the left, then a right snap onto the largest edge
        send(mk_item(0, CMAX, CMIN, CMAX, CMAX, CMIN, 1, 0));
        send(mk_item(CMIN, 0, CMIN, CMAX, CMAX, CMIN, 1, 0));
        send(mk_item(CMAX - 2 * UNIT, 0, CMIN, CMAX, CMAX, CMIN, 1, 0));
        // inverted obstacle edges
        send(mk_item(50 * UNIT, 50 * UNIT, 100 * UNIT, 0, 0, 100 * UNIT, 1, 0));
        send(mk_item(45 * UNIT, 50 * UNIT, 60 * UNIT, 50 * UNIT, 100 * UNIT, 0, 1, 0));
        // all-zero and all-one fields, far corner
        send(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
        send(mk_item(-1, -1, -1, -1, -1, -1, 1, 0));
        send(mk_item(CMAX, CMIN, 0, 100 * UNIT, 100 * UNIT, 0, 1, 0));
        drain();

        // Random phases over a range of box sizes, a moderate size first, then the extremes
        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    wv = 8 * UNIT;
                    hv = 8 * UNIT;
                end
                1: begin
                    wv = '0;
                    hv = '0;
                end
                2: begin
                    wv = DIM_MAX;
                    hv = DIM_MAX;
                end
                3: begin
                    wv = DIM_MAX;
                    hv = '0;
                end
                4: begin
                    wv = '0;
                    hv = DIM_MAX;
                end
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        wv = CFG_DATA_BITS'($urandom_range(0, 48) * UNIT);
                        hv = CFG_DATA_BITS'($urandom_range(0, 48) * UNIT);
                    end else begin
                        wv = CFG_DATA_BITS'($urandom);
                        hv = CFG_DATA_BITS'($urandom);
                    end
                end
            endcase
            set_box(wv, hv);
            // last phase runs back to back with no idling
            if (ph == 9) calm = 1'b1;
            repeat (120) send(rand_item());
            drain();
        end

        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
rtl/acr_pkg.sv
rtl/acr_in_if.sv
rtl/acr_out_if.sv
rtl/acr_resolve.sv
rtl/aabb_collision_resolver_top.sv
sim/tb.sv
